### rtl/core/partial_reliability_arq_sender_defines.svh
// Assertion macros used by the checker of the ARQ sender.
`ifndef PARTIAL_RELIABILITY_ARQ_SENDER_DEFINES_SVH
`define PARTIAL_RELIABILITY_ARQ_SENDER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PRAS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define PRAS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

### rtl/core/pras_pkg.sv
// Types, constants and codes of the partial reliability ARQ sender.
`default_nettype none
package pras_pkg;

   localparam int WINDOW     = 5;
   localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int LOSS_STEP  = 100 / WINDOW;
   localparam int LOSS_W     = 7;
   localparam int TRIES_W    = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LOSS_W-1:0]  MAX_LOSS_RESET  = 7'd20;
   localparam logic [TRIES_W-1:0] MAX_TRIES_RESET = 4'd10;

   typedef enum logic [1:0] {
      OP_SEND    = 2'd0,
      OP_PDU     = 2'd1,
      OP_TIMEOUT = 2'd2,
      OP_IGNORE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_ACKED       = 2'd0,
      ST_LOST_SINGLE = 2'd1,
      ST_FAILED      = 2'd2
   } status_type;

   typedef enum logic {
      CSR_MAX_LOSS  = 1'b0,
      CSR_MAX_TRIES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       flag_syn;
      logic       flag_ack;
      logic       flag_fin;
      logic       ack_number;
   } req_item_type;

   typedef struct packed {
      logic              transmit;
      logic              tx_seq;
      logic              done_res;
      status_type        status;
      logic [LOSS_W-1:0] loss_percent;
   } rsp_item_type;

   typedef struct packed {
      logic en;
      logic delivered;
   } ring_wr_type;

endpackage
`default_nettype wire

### rtl/core/pras_if.sv
// Request and response channel interfaces of the ARQ sender.
`default_nettype none
interface pras_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic       flag_syn;
   logic       flag_ack;
   logic       flag_fin;
   logic       ack_number;

   modport source (output valid, operation, flag_syn, flag_ack, flag_fin, ack_number,
                   input ready);
   modport sink   (input valid, operation, flag_syn, flag_ack, flag_fin, ack_number,
                   output ready);
endinterface

interface pras_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        transmit;
   logic                        tx_seq;
   logic                        done_res;
   logic [1:0]                  status;
   logic [pras_pkg::LOSS_W-1:0] loss_percent;

   modport source (output valid, transmit, tx_seq, done_res, status, loss_percent,
                   input ready);
   modport sink   (input valid, transmit, tx_seq, done_res, status, loss_percent,
                   output ready);
endinterface
`default_nettype wire

### rtl/core/partial_reliability_arq_sender.sv
// Top level of the partial reliability stop-and-wait ARQ sender.
//
// Usage:
//   req_if carries events: a send request, an arrived PDU header (syn, ack,
//   fin flags and the acknowledged sequence bit) or an acknowledgement timeout.
//   rsp_if carries at most one result beat per event: transmit now, the
//   sequence bit, message done, the final status and the loss percent seen
//   at the send request. Events that change nothing (send while waiting,
//   PDU or timeout while idle, the unused operation code) give no beat.
//   The CSR port holds the tolerated loss percent (address 0) and the
//   allowed tries per message (address 4); write them while the block idles.
// Timing:
//   An event is registered in the input register on accept and decided
//   there; its result lands in the output register, which drives the beat.
//   One event per cycle is sustained unless a result beat stalls; the
//   decision logic (ring popcount, loss compare, try counter) is a single
//   registered stage.
// Reset:
//   Synchronous reset empties both stages, marks every ring entry delivered,
//   clears the sequence bits and try counters, and restores both registers.
// Backpressure:
//   A stalled result beat holds in the output register; one more event can
//   wait in the input register behind it, then req_if.ready drops.
`default_nettype none
module partial_reliability_arq_sender (
   input  wire logic                            clock,
   input  wire logic                            reset,
   pras_req_if.sink                             req_if,
   pras_rsp_if.source                           rsp_if,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [pras_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [pras_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [pras_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);

   // configuration registers
   logic [pras_pkg::LOSS_W-1:0]  max_loss_ff;
   logic [pras_pkg::TRIES_W-1:0] max_tries_ff;
   pras_pkg::csr_index_type      csr_index;
   logic                         csr_write;

   // input stage
   logic                  in_valid_ff;
   pras_pkg::req_item_type in_item_ff;

   // protocol state
   logic                         next_seq_ff,   next_seq_in;
   logic                         out_seq_ff,    out_seq_in;
   logic                         waiting_ff,    waiting_in;
   logic [pras_pkg::TRIES_W-1:0] tries_done_ff, tries_done_in;
   logic [pras_pkg::TRIES_W-1:0] tries_allow_ff, tries_allow_in;

   // output stage
   logic                   rsp_valid_ff;
   pras_pkg::rsp_item_type rsp_item_ff;

   // decision
   logic                         advance;
   logic                         take;
   logic                         res_valid;
   pras_pkg::rsp_item_type       res_item;
   pras_pkg::ring_wr_type        ring_wr;
   logic [pras_pkg::LOSS_W-1:0]  loss_percent;
   logic                         good_ack;
   pras_pkg::op_type             op;

   // ---------------------------------------------------------------
   // CSR port: write on the access phase, read returns the register
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = pras_pkg::csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         pras_pkg::CSR_MAX_LOSS:  csr_prdata = pras_pkg::CSR_DATA_W'(max_loss_ff);
         pras_pkg::CSR_MAX_TRIES: csr_prdata = pras_pkg::CSR_DATA_W'(max_tries_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_loss_ff  <= pras_pkg::MAX_LOSS_RESET;
         max_tries_ff <= pras_pkg::MAX_TRIES_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            pras_pkg::CSR_MAX_LOSS:  max_loss_ff  <= csr_pwdata[pras_pkg::LOSS_W-1:0];
            pras_pkg::CSR_MAX_TRIES: max_tries_ff <= csr_pwdata[pras_pkg::TRIES_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Flow control: the input stage moves on whenever the output
   // register is empty or being drained this cycle.
   // ---------------------------------------------------------------
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign take         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_item_ff.operation  <= req_if.operation;
         in_item_ff.flag_syn   <= req_if.flag_syn;
         in_item_ff.flag_ack   <= req_if.flag_ack;
         in_item_ff.flag_fin   <= req_if.flag_fin;
         in_item_ff.ack_number <= req_if.ack_number;
      end
   end

   // ---------------------------------------------------------------
   // Outcome ring and loss percent
   // ---------------------------------------------------------------
   pras_loss_ring u_loss_ring (
      .clock        (clock),
      .reset        (reset),
      .record       (ring_wr),
      .loss_percent (loss_percent)
   );

   // ---------------------------------------------------------------
   // Decision for the registered event
   // ---------------------------------------------------------------
   assign op       = pras_pkg::op_type'(in_item_ff.operation);
   assign good_ack = !in_item_ff.flag_syn && in_item_ff.flag_ack && !in_item_ff.flag_fin
                     && (in_item_ff.ack_number == out_seq_ff);

   always_comb begin
      next_seq_in    = next_seq_ff;
      out_seq_in     = out_seq_ff;
      waiting_in     = waiting_ff;
      tries_done_in  = tries_done_ff;
      tries_allow_in = tries_allow_ff;
      ring_wr        = '0;
      res_valid      = 1'b0;
      res_item       = '0;
      res_item.tx_seq = out_seq_ff;

      unique case (op)
         pras_pkg::OP_SEND: begin
            if (!waiting_ff) begin
               // single shot when recent loss is tolerated
               if (loss_percent < max_loss_ff) begin
                  tries_allow_in = pras_pkg::TRIES_W'(1);
               end else if (max_tries_ff == '0) begin
                  tries_allow_in = pras_pkg::TRIES_W'(1);
               end else begin
                  tries_allow_in = max_tries_ff;
               end
               out_seq_in            = next_seq_ff;
               next_seq_in           = !next_seq_ff;
               tries_done_in         = pras_pkg::TRIES_W'(1);
               waiting_in            = 1'b1;
               res_valid             = 1'b1;
               res_item.transmit     = 1'b1;
               res_item.tx_seq       = next_seq_ff;
               res_item.loss_percent = loss_percent;
            end
         end
         pras_pkg::OP_PDU,
         pras_pkg::OP_TIMEOUT: begin
            if (waiting_ff) begin
               res_valid = 1'b1;
               priority if (op == pras_pkg::OP_PDU && good_ack) begin
                  ring_wr.en        = 1'b1;
                  ring_wr.delivered = 1'b1;
                  waiting_in        = 1'b0;
                  res_item.done_res = 1'b1;
                  res_item.status   = pras_pkg::ST_ACKED;
               end else if (tries_done_ff < tries_allow_ff) begin
                  // retransmit, count the try
                  tries_done_in     = tries_done_ff + 1'b1;
                  res_item.transmit = 1'b1;
               end else begin
                  // give up: out of tries
                  ring_wr.en        = 1'b1;
                  ring_wr.delivered = 1'b0;
                  waiting_in        = 1'b0;
                  res_item.done_res = 1'b1;
                  res_item.status   = (tries_allow_ff == pras_pkg::TRIES_W'(1))
                                      ? pras_pkg::ST_LOST_SINGLE : pras_pkg::ST_FAILED;
               end
            end
         end
         pras_pkg::OP_IGNORE: ;
         default: ;
      endcase

      // drop every side effect unless the event is actually taken
      if (!take) begin
         ring_wr.en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff    <= 1'b0;
         out_seq_ff     <= 1'b0;
         waiting_ff     <= 1'b0;
         tries_done_ff  <= '0;
         tries_allow_ff <= '0;
      end else if (take) begin
         next_seq_ff    <= next_seq_in;
         out_seq_ff     <= out_seq_in;
         waiting_ff     <= waiting_in;
         tries_done_ff  <= tries_done_in;
         tries_allow_ff <= tries_allow_in;
      end
   end

   // ---------------------------------------------------------------
   // Output register: hold while stalled, load on take
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= take && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         rsp_item_ff <= res_item;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.transmit     = rsp_item_ff.transmit;
   assign rsp_if.tx_seq       = rsp_item_ff.tx_seq;
   assign rsp_if.done_res     = rsp_item_ff.done_res;
   assign rsp_if.status       = rsp_item_ff.status;
   assign rsp_if.loss_percent = rsp_item_ff.loss_percent;

endmodule
`default_nettype wire

### rtl/core/pras_loss_ring.sv
// Ring of recent message outcomes and the loss percent drawn from it.
`default_nettype none
module pras_loss_ring (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pras_pkg::ring_wr_type       record,
   output logic [pras_pkg::LOSS_W-1:0]      loss_percent
);

   logic [pras_pkg::WINDOW-1:0] ring_ff;
   logic [pras_pkg::PTR_W-1:0]  ptr_ff;
   logic [pras_pkg::CNT_W-1:0]  lost_cnt;

   // 1 = delivered; count the lost entries
   always_comb begin
      lost_cnt = pras_pkg::CNT_W'($countones(~ring_ff));
      loss_percent = pras_pkg::LOSS_W'(lost_cnt) * pras_pkg::LOSS_W'(pras_pkg::LOSS_STEP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= '1;
         ptr_ff  <= '0;
      end else if (record.en) begin
         ring_ff[ptr_ff] <= record.delivered;
         if (ptr_ff == pras_pkg::PTR_W'(pras_pkg::WINDOW - 1)) begin
            ptr_ff <= '0;
         end else begin
            ptr_ff <= ptr_ff + 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

### rtl/core/pras_checker.sv
// Port-level checker of the ARQ sender result channel, bound to the top.
`default_nettype none
`include "partial_reliability_arq_sender_defines.svh"
module pras_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        transmit,
   input wire logic                        tx_seq,
   input wire logic                        done_res,
   input wire logic [1:0]                  status,
   input wire logic [pras_pkg::LOSS_W-1:0] loss_percent
);

   logic [pras_pkg::LOSS_W+4:0] beat_bits;

   assign beat_bits = {transmit, tx_seq, done_res, status, loss_percent};

   `PRAS_ASSERT_SAME(a_quiet_after_reset, $past(reset), !rsp_valid)
   `PRAS_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(beat_bits))
   `PRAS_ASSERT_SAME(a_tx_or_done, rsp_valid, !(transmit && done_res))
   `PRAS_ASSERT_SAME(a_status_at_done, rsp_valid && (status != pras_pkg::ST_ACKED), done_res)
   `PRAS_ASSERT_SAME(a_loss_on_send, rsp_valid && (loss_percent != '0), transmit && !done_res)

endmodule

bind partial_reliability_arq_sender pras_checker u_pras_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .transmit     (rsp_if.transmit),
   .tx_seq       (rsp_if.tx_seq),
   .done_res     (rsp_if.done_res),
   .status       (rsp_if.status),
   .loss_percent (rsp_if.loss_percent)
);
`default_nettype wire
